/* design/smm_pkg.sv */
`default_nettype none

package smm_pkg;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_LOAD_A  = 2'd0;
    localparam func_t FUNC_LOAD_B  = 2'd1;
    localparam func_t FUNC_COMPUTE = 2'd2;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_ROWS_A    = 2'd0;
    localparam reg_index_t REG_INNER_DIM = 2'd1;
    localparam reg_index_t REG_COLS_B    = 2'd2;

    localparam int CFG_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 3;
    localparam int PRODUCT_W = 2 * VALUE_W;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NEXT,
        ST_ISSUE,
        ST_WAIT
    } ctrl_state_t;

    // One multiply-accumulate step travelling down the datapath.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic use_prod;
    } mac_tok_t;

    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
    } mac_res_t;

endpackage

`default_nettype wire

/* design/smm_if.sv */
`default_nettype none

interface smm_in_if;
    import smm_pkg::*;

    logic                      valid;
    logic                      ready;
    func_t                     func;
    logic [POS_W-1:0]          elem_row;
    logic [POS_W-1:0]          elem_col;
    logic signed [VALUE_W-1:0] element_value;

    modport source (output valid, func, elem_row, elem_col, element_value, input ready);
    modport sink (input valid, func, elem_row, elem_col, element_value, output ready);
endinterface

interface smm_out_if;
    import smm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [POS_W-1:0]          out_row;
    logic [POS_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;

    modport source (output valid, out_row, out_col, out_value, last, input ready);
    modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

`default_nettype wire

/* design/small_matrix_multiply_unit.sv */
`default_nettype none

// Fixed-point product of A (rows_a x inner_dim) and B (inner_dim x cols_b), signed
// Q(31-FRAC_BITS).FRAC_BITS, each dimension up to MAX_DIM. A load word writes one
// element into the A or B memory when its row and column lie in range. A compute word
// emits the product elements in row-major order with last on the final one. Speed
// is set by the single shared 32x32 multiplier, which reads one A and one B element
// per cycle from the two single-read-port memories while an element is issued,
// plus the read, multiply, accumulate and output registers in the element loop; a
// new element starts only after the previous result is loaded into the output word.
// Sums are kept exactly, shifted right arithmetically and saturated to 32 bits.
// New words are taken only between compute runs.
module small_matrix_multiply_unit
    import smm_pkg::*;
#(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    smm_in_if.sink                 items,
    smm_out_if.source              results,
    input  wire logic              cfg_we,
    input  wire reg_index_t        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0]   rows_a_reg;
    logic [CFG_W-1:0]   inner_dim_reg;
    logic [CFG_W-1:0]   cols_b_reg;
    logic               we_a;
    logic               we_b;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
    logic [VALUE_W-1:0] rdata_a;
    logic [VALUE_W-1:0] rdata_b;
    mac_tok_t           tok;
    mac_res_t           res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    smm_ctrl #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .results   (results),
        .rows_a    (rows_a_reg),
        .inner_dim (inner_dim_reg),
        .cols_b    (cols_b_reg),
        .we_a      (we_a),
        .we_b      (we_b),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b),
        .tok       (tok),
        .res       (res)
    );

    smm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    smm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    smm_mac #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok    (tok),
        .a_data (rdata_a),
        .b_data (rdata_b),
        .res    (res)
    );

endmodule

`default_nettype wire

/* design/smm_mem.sv */
`default_nettype none

module smm_mem
    import smm_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire logic [VALUE_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]  raddr,
    output logic      [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/smm_mac.sv */
`default_nettype none

module smm_mac
    import smm_pkg::*;
#(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mac_tok_t           tok,
    input  wire logic [VALUE_W-1:0] a_data,
    input  wire logic [VALUE_W-1:0] b_data,
    output mac_res_t                res
);

    // Room for the sum of MAX_DIM full-width products without loss.
    localparam int ACC_W = PRODUCT_W + $clog2(MAX_DIM + 1);

    mac_tok_t                    s1_reg;
    mac_tok_t                    s2_reg;
    logic signed [PRODUCT_W-1:0] prod_reg;
    logic signed [PRODUCT_W-1:0] prod_next;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     sum_reg;
    logic signed [ACC_W-1:0]     sum_next;
    logic                        sum_valid_reg;
    logic signed [ACC_W-1:0]     shifted;
    logic [ACC_W-32:0]           upper;

    // The token is registered in s1_reg so that it lines up with the registered read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= tok;
            s2_reg        <= s1_reg;
            sum_valid_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    always_comb
    begin
        if (s1_reg.use_prod)
        begin
            prod_next = $signed(a_data) * $signed(b_data);
        end
        else
        begin
            prod_next = '0;
        end
        sum_next = (s2_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (s2_reg.valid)
        begin
            acc_reg <= sum_next;
            if (s2_reg.last)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    // Shift out the fraction bits, then clamp to the signed 32-bit range.
    always_comb
    begin
        shifted   = sum_reg >>> FRAC_BITS;
        upper     = shifted[ACC_W-1:31];
        res.valid = sum_valid_reg;
        if ((&upper) || !(|upper))
        begin
            res.value = shifted[VALUE_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            res.value = 32'sh8000_0000;
        end
        else
        begin
            res.value = 32'sh7FFF_FFFF;
        end
    end

endmodule

`default_nettype wire

/* design/smm_ctrl.sv */
`default_nettype none

module smm_ctrl
    import smm_pkg::*;
#(
    parameter int MAX_DIM = 4,
    parameter int ADDR_W  = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    smm_in_if.sink                  items,
    smm_out_if.source               results,
    input  wire logic [CFG_W-1:0]   rows_a,
    input  wire logic [CFG_W-1:0]   inner_dim,
    input  wire logic [CFG_W-1:0]   cols_b,
    output logic                    we_a,
    output logic                    we_b,
    output logic [ADDR_W-1:0]       waddr,
    output logic [VALUE_W-1:0]      wdata,
    output logic [ADDR_W-1:0]       raddr_a,
    output logic [ADDR_W-1:0]       raddr_b,
    output mac_tok_t                tok,
    input  wire mac_res_t           res
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    ctrl_state_t               state_reg;
    ctrl_state_t               state_next;
    logic [IDX_W-1:0]          i_reg;
    logic [IDX_W-1:0]          i_next;
    logic [IDX_W-1:0]          j_reg;
    logic [IDX_W-1:0]          j_next;
    logic [IDX_W-1:0]          k_reg;
    logic [IDX_W-1:0]          k_next;
    logic [DIM_W-1:0]          nr_reg;
    logic [DIM_W-1:0]          nk_reg;
    logic [DIM_W-1:0]          nc_reg;
    logic [DIM_W-1:0]          nr_eff;
    logic [DIM_W-1:0]          nk_eff;
    logic [DIM_W-1:0]          nc_eff;
    logic                      capture_dims;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [POS_W-1:0]          out_row_reg;
    logic [POS_W-1:0]          out_col_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic                      load_out;
    logic                      out_last_next;
    logic                      out_free;
    logic                      accept;
    logic                      in_range;
    logic                      k_last;
    logic                      j_last;
    logic                      i_last;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] value);
        if (value > CFG_W'(MAX_DIM))
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(value);
    endfunction

    assign nr_eff   = eff_dim(rows_a);
    assign nk_eff   = eff_dim(inner_dim);
    assign nc_eff   = eff_dim(cols_b);
    assign accept   = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign in_range = (CFG_W'(items.elem_row) < CFG_W'(MAX_DIM))
                   && (CFG_W'(items.elem_col) < CFG_W'(MAX_DIM));

    assign we_a  = accept && (items.func == FUNC_LOAD_A) && in_range;
    assign we_b  = accept && (items.func == FUNC_LOAD_B) && in_range;
    assign waddr = ADDR_W'(32'(items.elem_row) * MAX_DIM + 32'(items.elem_col));
    assign wdata = items.element_value;

    assign raddr_a = ADDR_W'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign raddr_b = ADDR_W'(32'(k_reg) * MAX_DIM + 32'(j_reg));

    assign k_last = (nk_reg == '0) || ((DIM_W'(k_reg) + DIM_W'(1)) == nk_reg);
    assign j_last = (DIM_W'(j_reg) + DIM_W'(1)) == nc_reg;
    assign i_last = (DIM_W'(i_reg) + DIM_W'(1)) == nr_reg;

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        capture_dims  = 1'b0;
        load_out      = 1'b0;
        out_last_next = 1'b0;
        items.ready   = 1'b0;
        tok           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
                if (accept && (items.func == FUNC_COMPUTE))
                begin
                    capture_dims = 1'b1;
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                    // An empty product finishes on the spot.
                    if ((nr_eff != '0) && (nc_eff != '0))
                    begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                // Start an element only once the output word is free, so its
                // result always finds room.
                if (out_free)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                tok.valid    = 1'b1;
                tok.first    = (k_reg == '0);
                tok.last     = k_last;
                tok.use_prod = (nk_reg != '0);
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (res.valid)
                begin
                    load_out = 1'b1;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_NEXT;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_NEXT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture_dims)
        begin
            nr_reg <= nr_eff;
            nk_reg <= nk_eff;
            nc_reg <= nc_eff;
        end
        if (load_out)
        begin
            out_row_reg   <= POS_W'(i_reg);
            out_col_reg   <= POS_W'(j_reg);
            out_value_reg <= res.value;
            out_last_reg  <= out_last_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_row   = out_row_reg;
    assign results.out_col   = out_col_reg;
    assign results.out_value = out_value_reg;
    assign results.last      = out_last_reg;

`ifndef NO_ASSERTIONS
    a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (state_reg == ST_WAIT))
        else $error("product element finished outside of the wait state");

    a_res_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!out_valid_reg || results.ready))
        else $error("product element finished while the output word was full");

    a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(res.valid))
        else $error("output word appeared without a finished product element");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ISSUE) && (nk_reg != '0)) |-> (DIM_W'(k_reg) < nk_reg))
        else $error("inner index ran past the inner dimension");
`endif

endmodule

`default_nettype wire
